// File: rtl/alpha_fade_envelope_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef ALPHA_FADE_ENVELOPE_UNIT_ASSERT_SVH
`define ALPHA_FADE_ENVELOPE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define AFE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define AFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/afe_pkg.sv
package afe_pkg;

   localparam int TIME_WIDTH_DEF  = 24;
   localparam int DELTA_WIDTH_DEF = 16;

   localparam int REG_W      = 24;
   localparam int MODE_W     = 2;
   localparam int ALPHA_W    = 8;
   localparam int PHASE_W    = 3;
   localparam int REQ_W      = 2;
   localparam int CSR_ADDR_W = 4;
   localparam int PROD_W     = REG_W + ALPHA_W;
   localparam int STEP_W     = $clog2(ALPHA_W);

   localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = '1;
   localparam logic [ALPHA_W-1:0] ALPHA_CLEAR  = '0;

   // register map
   localparam logic [CSR_ADDR_W-1:0] CSR_FADE_MODE = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOLD      = 4'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FADE_IN   = 4'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_FADE_OUT  = 4'd3;

   // fade modes
   localparam logic [MODE_W-1:0] MODE_IN_HOLD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HOLD_OUT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FULL     = 2'd2;

   typedef enum logic [REQ_W-1:0] {
      REQ_TICK  = 2'd0,
      REQ_PLAY  = 2'd1,
      REQ_RESET = 2'd2
   } req_code_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_IDLE = 3'd0,
      PH_IN   = 3'd1,
      PH_HOLD = 3'd2,
      PH_OUT  = 3'd3,
      PH_FIN  = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_SUM,
      CS_DECIDE,
      CS_DIV,
      CS_WRITE
   } ctl_state_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_PREP,
      DV_RUN
   } div_state_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [REG_W-1:0]  hold;
      logic [REG_W-1:0]  fade_in;
      logic [REG_W-1:0]  fade_out;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [REG_W-1:0] num;
      logic [REG_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [ALPHA_W-1:0] quot;
   } div_rsp_type;

endpackage

// File: rtl/afe_if.sv
interface afe_req_if #(
   parameter int DELTA_WIDTH = afe_pkg::DELTA_WIDTH_DEF
);
   import afe_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [REQ_W-1:0]       req_type;
   logic [DELTA_WIDTH-1:0] delta_ticks;

   modport source (output valid, output req_type, output delta_ticks, input ready);
   modport sink   (input valid, input req_type, input delta_ticks, output ready);
endinterface

interface afe_rsp_if;
   import afe_pkg::*;

   logic               valid;
   logic               ready;
   logic [ALPHA_W-1:0] alpha;
   logic [PHASE_W-1:0] phase;
   logic               done_res;

   modport source (output valid, output alpha, output phase, output done_res, input ready);
   modport sink   (input valid, input alpha, input phase, input done_res, output ready);
endinterface

interface afe_csr_if;
   import afe_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [REG_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/alpha_fade_envelope_unit.sv
// Alpha fade envelope: fade in/hold, hold/fade out or fade in/hold/fade out,
// driven by play, reset and tick requests, one response beat per request.
// A request that needs no alpha division (play, reset, fade end, hold) goes
// through the sum, decide and write states after accept: sum adds the elapsed
// time, decide compares against the duration, write loads the response. A tick
// inside a fade goes from decide to the restoring divider, which runs a setup
// state and a bit loop over the eight quotient bits on floor(255*e/d) for a
// fade in or floor(255*(d-e)/d) for a fade out; the div state takes the
// quotient and write loads the response. The request side is not ready while
// an item is in flight, so no new request is taken before the last is through;
// it is ready again once the response is loaded, later while the previous beat
// still waits in the response register. Configuration writes are accepted
// every cycle and must only be issued while no request is in flight.
module alpha_fade_envelope_unit #(
   parameter int TIME_WIDTH  = afe_pkg::TIME_WIDTH_DEF,
   parameter int DELTA_WIDTH = afe_pkg::DELTA_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   afe_req_if.sink   req_bus,
   afe_rsp_if.source rsp_bus,
   afe_csr_if.sink   csr_bus
);
   import afe_pkg::*;

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [REG_W-1:0]  hold_ff, hold_in;
   logic [REG_W-1:0]  fade_in_ff, fade_in_in;
   logic [REG_W-1:0]  fade_out_ff, fade_out_in;
   cfg_type           cfg;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= '0;
         hold_ff     <= '0;
         fade_in_ff  <= '0;
         fade_out_ff <= '0;
      end else begin
         mode_ff     <= mode_in;
         hold_ff     <= hold_in;
         fade_in_ff  <= fade_in_in;
         fade_out_ff <= fade_out_in;
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      hold_in     = hold_ff;
      fade_in_in  = fade_in_ff;
      fade_out_in = fade_out_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_FADE_MODE: mode_in     = csr_bus.data[MODE_W-1:0];
            CSR_HOLD:      hold_in     = csr_bus.data;
            CSR_FADE_IN:   fade_in_in  = csr_bus.data;
            CSR_FADE_OUT:  fade_out_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   assign csr_bus.ready = 1'b1;

   assign cfg.mode     = mode_ff;
   assign cfg.hold     = hold_ff;
   assign cfg.fade_in  = fade_in_ff;
   assign cfg.fade_out = fade_out_ff;

   afe_ctrl #(
      .TIME_WIDTH  (TIME_WIDTH),
      .DELTA_WIDTH (DELTA_WIDTH)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   afe_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule

// File: rtl/afe_div.sv
// Restoring divider, one quotient bit per cycle: quot = floor(255*num/den).
// Requires num <= den, so the quotient fits in eight bits.
module afe_div (
   input  logic                 clock,
   input  logic                 reset,
   input  afe_pkg::div_req_type div_req,
   output afe_pkg::div_rsp_type div_rsp
);
   import afe_pkg::*;

   div_state_type        state_ff, state_in;
   logic [REG_W-1:0]     num_ff, num_in;
   logic [REG_W-1:0]     den_ff, den_in;
   logic [REG_W-1:0]     rem_ff, rem_in;
   logic [ALPHA_W-1:0]   lo_ff, lo_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [PROD_W-1:0]    prod;
   logic [REG_W:0]       trial;
   logic [REG_W+1:0]     diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      cnt_ff <= cnt_in;
   end

   // 255*x as (x << 8) - x
   assign prod  = {num_ff, {ALPHA_W{1'b0}}} - PROD_W'(num_ff);
   assign trial = {rem_ff, lo_ff[ALPHA_W-1]};
   assign diff  = (REG_W+2)'(trial) - (REG_W+2)'(den_ff);

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      lo_in    = lo_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      case (state_ff)
         DV_IDLE: begin
            if (div_req.start) begin
               num_in   = div_req.num;
               den_in   = div_req.den;
               state_in = DV_PREP;
            end
         end
         DV_PREP: begin
            // upper part is already below den since 255*num < 256*den
            rem_in   = prod[PROD_W-1:ALPHA_W];
            lo_in    = prod[ALPHA_W-1:0];
            cnt_in   = STEP_W'(ALPHA_W - 1);
            state_in = DV_RUN;
         end
         DV_RUN: begin
            // quotient bits shift in behind the dividend bits
            rem_in = diff[REG_W+1] ? trial[REG_W-1:0] : diff[REG_W-1:0];
            lo_in  = {lo_ff[ALPHA_W-2:0], ~diff[REG_W+1]};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = DV_IDLE;
            end
         end
         default: state_in = DV_IDLE;
      endcase
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = lo_ff;

endmodule

// File: rtl/afe_ctrl.sv
// Envelope sequencer: elapsed add, limit compare, phase update, then hands
// the alpha ratio to the divider inside a fade and registers the result beat.
module afe_ctrl #(
   parameter int TIME_WIDTH  = afe_pkg::TIME_WIDTH_DEF,
   parameter int DELTA_WIDTH = afe_pkg::DELTA_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  afe_pkg::cfg_type     cfg,
   afe_req_if.sink              req_bus,
   afe_rsp_if.source            rsp_bus,
   output afe_pkg::div_req_type div_req,
   input  afe_pkg::div_rsp_type div_rsp
);
   import afe_pkg::*;

   localparam int SUM_W = (TIME_WIDTH > DELTA_WIDTH ? TIME_WIDTH : DELTA_WIDTH) + 1;
   localparam int CMP_W = SUM_W > REG_W ? SUM_W : REG_W;

   ctl_state_type          state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic [TIME_WIDTH-1:0]  fade_el_ff, fade_el_in;
   logic [TIME_WIDTH-1:0]  hold_el_ff, hold_el_in;
   logic [ALPHA_W-1:0]     alpha_ff, alpha_in;
   req_code_type           req_ff, req_in;
   logic [DELTA_WIDTH-1:0] delta_ff, delta_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   done_ff, done_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ALPHA_W-1:0]     rsp_alpha_ff, rsp_alpha_in;
   logic [PHASE_W-1:0]     rsp_phase_ff, rsp_phase_in;
   logic                   rsp_done_ff, rsp_done_in;

   logic [REG_W-1:0]       limit;
   logic [CMP_W-1:0]       sum_ext;
   logic [CMP_W:0]         diff;
   logic                   reached;
   logic [TIME_WIDTH-1:0]  sum_sat;
   logic                   begin_hold;
   logic                   leave_hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         phase_ff     <= PH_IDLE;
         fade_el_ff   <= '0;
         hold_el_ff   <= '0;
         alpha_ff     <= ALPHA_OPAQUE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         fade_el_ff   <= fade_el_in;
         hold_el_ff   <= hold_el_in;
         alpha_ff     <= alpha_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      delta_ff     <= delta_in;
      sum_ff       <= sum_in;
      done_ff      <= done_in;
      rsp_alpha_ff <= rsp_alpha_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_done_ff  <= rsp_done_in;
   end

   always_comb begin
      case (phase_ff)
         PH_IN:   limit = cfg.fade_in;
         PH_OUT:  limit = cfg.fade_out;
         default: limit = cfg.hold;
      endcase
   end

   // sum >= limit when limit - sum is zero or negative
   assign sum_ext = CMP_W'(sum_ff);
   assign diff    = (CMP_W+1)'(limit) - (CMP_W+1)'(sum_ext);
   assign reached = diff[CMP_W] || (diff == '0);
   assign sum_sat = (sum_ff[SUM_W-1:TIME_WIDTH] != '0) ? '1 : sum_ff[TIME_WIDTH-1:0];

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      fade_el_in   = fade_el_ff;
      hold_el_in   = hold_el_ff;
      alpha_in     = alpha_ff;
      req_in       = req_ff;
      delta_in     = delta_ff;
      sum_in       = sum_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_alpha_in = rsp_alpha_ff;
      rsp_phase_in = rsp_phase_ff;
      rsp_done_in  = rsp_done_ff;
      div_req      = '0;
      begin_hold   = 1'b0;
      leave_hold   = 1'b0;

      case (state_ff)
         CS_IDLE: begin
            if (req_bus.valid) begin
               req_in   = req_code_type'(req_bus.req_type);
               delta_in = req_bus.delta_ticks;
               state_in = CS_SUM;
            end
         end
         CS_SUM: begin
            sum_in = SUM_W'(phase_ff == PH_HOLD ? hold_el_ff : fade_el_ff)
                   + SUM_W'(delta_ff);
            state_in = CS_DECIDE;
         end
         CS_DECIDE: begin
            state_in = CS_WRITE;
            case (req_ff)
               REQ_PLAY: begin
                  fade_el_in = '0;
                  if (cfg.mode == MODE_IN_HOLD || cfg.mode == MODE_FULL) begin
                     alpha_in = ALPHA_CLEAR;
                     phase_in = PH_IN;
                  end else if (cfg.mode == MODE_HOLD_OUT) begin
                     alpha_in   = ALPHA_OPAQUE;
                     begin_hold = 1'b1;
                  end
               end
               REQ_RESET: begin
                  phase_in   = PH_IDLE;
                  fade_el_in = '0;
                  hold_el_in = '0;
                  alpha_in   = ALPHA_OPAQUE;
               end
               REQ_TICK: begin
                  case (phase_ff)
                     PH_IN: begin
                        if (reached) begin
                           fade_el_in = '0;
                           alpha_in   = ALPHA_OPAQUE;
                           begin_hold = 1'b1;
                        end else begin
                           fade_el_in    = sum_sat;
                           div_req.start = 1'b1;
                           div_req.num   = sum_ext[REG_W-1:0];
                           div_req.den   = cfg.fade_in;
                           state_in      = CS_DIV;
                        end
                     end
                     PH_HOLD: begin
                        hold_el_in = sum_sat;
                        leave_hold = reached;
                     end
                     PH_OUT: begin
                        fade_el_in = sum_sat;
                        if (reached) begin
                           alpha_in = ALPHA_CLEAR;
                           phase_in = PH_FIN;
                        end else begin
                           div_req.start = 1'b1;
                           div_req.num   = diff[REG_W-1:0];
                           div_req.den   = cfg.fade_out;
                           state_in      = CS_DIV;
                        end
                     end
                     default: ;
                  endcase
               end
               default: ;
            endcase

            if (begin_hold) begin
               if (cfg.hold == '0) begin
                  leave_hold = 1'b1;
               end else begin
                  hold_el_in = '0;
                  phase_in   = PH_HOLD;
               end
            end
            // mode 3 leaves the phase where it is
            if (leave_hold) begin
               if (cfg.mode == MODE_IN_HOLD) begin
                  phase_in = PH_FIN;
               end else if (cfg.mode == MODE_HOLD_OUT || cfg.mode == MODE_FULL) begin
                  fade_el_in = '0;
                  phase_in   = PH_OUT;
               end
            end
            done_in = (phase_in == PH_FIN) && (phase_ff != PH_FIN);
         end
         CS_DIV: begin
            if (div_rsp.done) begin
               alpha_in = div_rsp.quot;
               state_in = CS_WRITE;
            end
         end
         CS_WRITE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_alpha_in = alpha_ff;
               rsp_phase_in = phase_ff;
               rsp_done_in  = done_ff;
               state_in     = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   assign req_bus.ready    = (state_ff == CS_IDLE);
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.alpha    = rsp_alpha_ff;
   assign rsp_bus.phase    = rsp_phase_ff;
   assign rsp_bus.done_res = rsp_done_ff;

endmodule

// File: rtl/afe_checker.sv
`include "alpha_fade_envelope_unit_assert.svh"

module afe_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [afe_pkg::ALPHA_W-1:0] rsp_alpha,
   input logic [afe_pkg::PHASE_W-1:0] rsp_phase,
   input logic                        rsp_done
);
   import afe_pkg::*;

   `AFE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response beat dropped while stalled")
   `AFE_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "request taken while previous one in flight")
   `AFE_ASSERT_NOW(a_done_fin, clock, reset, rsp_valid && rsp_done, rsp_phase == PH_FIN, "done without finished phase")
   `AFE_ASSERT_NOW(a_opaque, clock, reset, rsp_valid && (rsp_phase == PH_IDLE || rsp_phase == PH_HOLD), rsp_alpha == ALPHA_OPAQUE, "idle or hold with alpha not opaque")

endmodule

bind alpha_fade_envelope_unit afe_checker u_afe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_alpha (rsp_bus.alpha),
   .rsp_phase (rsp_bus.phase),
   .rsp_done  (rsp_bus.done_res)
);

// File: tb/alpha_fade_envelope_unit_tb.sv
module alpha_fade_envelope_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import afe_pkg::*;

   localparam int DELTA_W      = DELTA_WIDTH_DEF;
   localparam int RANDOM_ITEMS = 1400;

   localparam logic [REQ_W-1:0]  REQ_UNUSED = 2'd3;
   localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;
   localparam logic [REG_W-1:0]  TIME_SAT   = '1;

   typedef struct packed {
      logic [ALPHA_W-1:0] alpha;
      logic [PHASE_W-1:0] phase;
      logic               done;
   } env_beat_type;

   // Tracks the envelope state and config, queues the expected response beats.
   class envelope_scoreboard;
      logic [MODE_W-1:0]  mode;
      logic [REG_W-1:0]   hold_len;
      logic [REG_W-1:0]   in_len;
      logic [REG_W-1:0]   out_len;
      phase_type          phase_now;
      logic [REG_W-1:0]   fade_t;
      logic [REG_W-1:0]   hold_t;
      logic [ALPHA_W-1:0] alpha_now;
      env_beat_type       pending_beats[$];
      int                 mismatches;

      function new();
         mode      = MODE_IN_HOLD;
         hold_len  = '0;
         in_len    = '0;
         out_len   = '0;
         phase_now = PH_IDLE;
         fade_t    = '0;
         hold_t    = '0;
         alpha_now = ALPHA_OPAQUE;
         mismatches = 0;
      endfunction

      function void write_reg(input logic [CSR_ADDR_W-1:0] index,
                              input logic [REG_W-1:0] data);
         case (index)
            CSR_FADE_MODE: mode     = data[MODE_W-1:0];
            CSR_HOLD:      hold_len = data;
            CSR_FADE_IN:   in_len   = data;
            CSR_FADE_OUT:  out_len  = data;
            default: ;
         endcase
      endfunction

      function logic [REG_W-1:0] clamp_time(input logic [REG_W:0] sum);
         return sum[REG_W] ? TIME_SAT : sum[REG_W-1:0];
      endfunction

      // mode 3 falls through both branches: phase stays put
      function void leave_hold();
         if (mode == MODE_IN_HOLD) begin
            phase_now = PH_FIN;
         end else if (mode == MODE_HOLD_OUT || mode == MODE_FULL) begin
            fade_t    = '0;
            phase_now = PH_OUT;
         end
      endfunction

      function void enter_hold();
         if (hold_len == '0) begin
            leave_hold();
         end else begin
            hold_t    = '0;
            phase_now = PH_HOLD;
         end
      endfunction

      function void take_request(input logic [REQ_W-1:0] kind,
                                 input logic [DELTA_W-1:0] delta);
         phase_type         was;
         logic [REG_W:0]    sum;
         logic [PROD_W-1:0] scaled;
         env_beat_type      beat;
         was = phase_now;
         if (kind == REQ_PLAY) begin
            fade_t = '0;
            if (mode == MODE_IN_HOLD || mode == MODE_FULL) begin
               alpha_now = ALPHA_CLEAR;
               phase_now = PH_IN;
            end else if (mode == MODE_HOLD_OUT) begin
               alpha_now = ALPHA_OPAQUE;
               enter_hold();
            end
         end else if (kind == REQ_RESET) begin
            phase_now = PH_IDLE;
            fade_t    = '0;
            hold_t    = '0;
            alpha_now = ALPHA_OPAQUE;
         end else if (kind == REQ_TICK) begin
            case (phase_now)
               PH_IN: begin
                  sum = fade_t + delta;
                  if (sum >= in_len) begin
                     fade_t    = '0;
                     alpha_now = ALPHA_OPAQUE;
                     enter_hold();
                  end else begin
                     fade_t    = clamp_time(sum);
                     scaled    = sum * 8'd255;
                     scaled    = scaled / in_len;
                     alpha_now = scaled[ALPHA_W-1:0];
                  end
               end
               PH_HOLD: begin
                  sum    = hold_t + delta;
                  hold_t = clamp_time(sum);
                  if (sum >= hold_len)
                     leave_hold();
               end
               PH_OUT: begin
                  sum    = fade_t + delta;
                  fade_t = clamp_time(sum);
                  if (sum >= out_len) begin
                     alpha_now = ALPHA_CLEAR;
                     phase_now = PH_FIN;
                  end else begin
                     scaled    = (out_len - sum) * 8'd255;
                     scaled    = scaled / out_len;
                     alpha_now = scaled[ALPHA_W-1:0];
                  end
               end
               default: ;
            endcase
         end
         beat.alpha = alpha_now;
         beat.phase = phase_now;
         beat.done  = (phase_now == PH_FIN && was != PH_FIN);
         pending_beats.push_back(beat);
      endfunction

      task report_mismatch(input string what);
         $display("[%0t] mismatch: %s", $time, what);
         mismatches++;
      endtask

      task match_response(input logic [ALPHA_W-1:0] alpha,
                          input logic [PHASE_W-1:0] phase,
                          input logic done);
         env_beat_type want;
         if (pending_beats.size() == 0) begin
            report_mismatch("response beat with nothing expected");
            return;
         end
         want = pending_beats.pop_front();
         if (alpha !== want.alpha)
            report_mismatch($sformatf("alpha %0d, expected %0d", alpha, want.alpha));
         if (phase !== want.phase)
            report_mismatch($sformatf("phase %0d, expected %0d", phase, want.phase));
         if (done !== want.done)
            report_mismatch($sformatf("done_res %0b, expected %0b", done, want.done));
      endtask

      task flag_leftovers();
         if (pending_beats.size() != 0)
            report_mismatch($sformatf("%0d expected beats never arrived",
                                      pending_beats.size()));
      endtask
   endclass

   logic clock;
   logic reset;

   afe_req_if #(.DELTA_WIDTH(DELTA_W)) req_bus();
   afe_rsp_if rsp_bus();
   afe_csr_if csr_bus();

   alpha_fade_envelope_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   envelope_scoreboard board = new();

   int idle_pct      = 11;
   int rsp_hold_left = 0;
   int busy_items    = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // response side: random stalls plus an occasional long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.match_response(rsp_bus.alpha, rsp_bus.phase, rsp_bus.done_res);
   end

   // called at a falling edge; returns at the falling edge after the beat
   task automatic send_item(input logic [REQ_W-1:0] kind, input logic [DELTA_W-1:0] delta);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= kind;
      req_bus.delta_ticks <= delta;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (!(kind == REQ_UNUSED ||
            (kind == REQ_TICK && (board.phase_now == PH_IDLE || board.phase_now == PH_FIN))))
         busy_items++;
      board.take_request(kind, delta);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (board.pending_beats.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] index, input logic [REG_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      board.write_reg(index, data);
      @(negedge clock);
   endtask

   // state is kept across writes; only the registers change
   task automatic program_envelope(input logic [MODE_W-1:0] mode,
                                   input logic [REG_W-1:0] hold_len,
                                   input logic [REG_W-1:0] in_len,
                                   input logic [REG_W-1:0] out_len);
      req_bus.valid <= 1'b0;
      wait_drained();
      csr_write(CSR_FADE_MODE, REG_W'(mode));
      csr_write(CSR_HOLD, hold_len);
      csr_write(CSR_FADE_IN, in_len);
      csr_write(CSR_FADE_OUT, out_len);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [MODE_W-1:0] pick_mode();
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5:      return MODE_IN_HOLD;
         6, 7, 8, 9, 10, 11:    return MODE_HOLD_OUT;
         19:                    return MODE_NONE;
         default:               return MODE_FULL;
      endcase
   endfunction

   function automatic logic [REG_W-1:0] pick_duration();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return REG_W'(1);
         2:       return '1;
         3:       return REG_W'($urandom_range(2, 20000));
         default: return REG_W'($urandom_range(2, 400));
      endcase
   endfunction

   // mostly steps sized to the current stage so sequences run to the end
   function automatic logic [DELTA_W-1:0] pick_delta(input logic [REG_W-1:0] stage_len);
      int unsigned span;
      span = stage_len / 6 + 1;
      if (span > (1 << DELTA_W) - 1)
         span = (1 << DELTA_W) - 1;
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return DELTA_W'($urandom);
         2:       return '1;
         default: return DELTA_W'($urandom_range(0, span));
      endcase
   endfunction

   task automatic run_sequence(input int seq_no);
      int               steps;
      int               step_cap;
      int               pick;
      logic [REG_W-1:0] stage_len;
      idle_pct = (seq_no >= 30 && seq_no < 45) ? 0 : 11;
      program_envelope(pick_mode(), pick_duration(), pick_duration(), pick_duration());
      // long receiver hold-off while requests keep coming
      if (seq_no % 50 == 10)
         rsp_hold_left = 250;
      send_item(REQ_PLAY, DELTA_W'($urandom));
      step_cap = $urandom_range(8, 60);
      for (steps = 0; steps < step_cap && board.phase_now != PH_FIN; steps++) begin
         pick = $urandom_range(0, 99);
         case (board.phase_now)
            PH_IN:   stage_len = board.in_len;
            PH_HOLD: stage_len = board.hold_len;
            default: stage_len = board.out_len;
         endcase
         if (pick < 5)
            send_item(REQ_W'($urandom_range(0, 3)), DELTA_W'($urandom));
         else if (pick == 5)
            program_envelope(pick_mode(), board.hold_len, board.in_len, board.out_len);
         else
            send_item(REQ_TICK, pick_delta(stage_len));
      end
      repeat ($urandom_range(0, 2)) send_item(REQ_TICK, DELTA_W'($urandom));
   endtask

   initial begin
      int seq_no;
      int base;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.req_type     = REQ_TICK;
      req_bus.delta_ticks  = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = CSR_FADE_MODE;
      csr_bus.data         = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // defaults: mode fade-in/hold with zero times
      send_item(REQ_TICK, '1);
      send_item(REQ_UNUSED, '0);
      send_item(REQ_RESET, '0);
      send_item(REQ_PLAY, '0);
      send_item(REQ_TICK, '0);
      send_item(REQ_TICK, 16'h5A5A);

      // full envelope through every phase, hold timeout discards the rest
      program_envelope(MODE_FULL, 24'd3, 24'd10, 24'd7);
      send_item(REQ_PLAY, '0);
      send_item(REQ_TICK, '0);
      send_item(REQ_TICK, 16'd3);
      send_item(REQ_TICK, 16'd5);
      send_item(REQ_TICK, 16'd2);
      send_item(REQ_TICK, 16'd1);
      send_item(REQ_TICK, '1);
      send_item(REQ_TICK, 16'd6);
      send_item(REQ_TICK, 16'd1);
      send_item(REQ_UNUSED, '1);

      // zero hold skipped straight into a maximal fade out
      program_envelope(MODE_HOLD_OUT, '0, '0, '1);
      send_item(REQ_PLAY, '0);
      send_item(REQ_TICK, '1);
      send_item(REQ_RESET, '1);

      // unused mode entered while holding: phase sticks
      program_envelope(MODE_HOLD_OUT, '1, '1, '0);
      send_item(REQ_PLAY, '0);
      program_envelope(MODE_NONE, '1, '1, '0);
      send_item(REQ_TICK, '1);
      send_item(REQ_PLAY, '0);
      send_item(REQ_TICK, 16'd1);
      send_item(REQ_RESET, '0);
      send_item(REQ_PLAY, '0);

      // instant fade in, then a short hold to the end
      program_envelope(MODE_IN_HOLD, 24'd2, '0, 24'd5);
      send_item(REQ_PLAY, '0);
      send_item(REQ_TICK, '0);
      send_item(REQ_TICK, 16'd2);

      base   = busy_items;
      seq_no = 0;
      while (busy_items - base < RANDOM_ITEMS) begin
         run_sequence(seq_no);
         seq_no++;
      end

      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (40) @(posedge clock);
      board.flag_leftovers();
      if (board.mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
